// File: hdl/tcce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_TEXT_ATTR = 2'd0;
    localparam logic [ATTR_W-1:0]  ATTR_RESET    = 8'h07;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_DRAW  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    typedef logic [2:0] kind_t;
    localparam kind_t OP_PRINT     = 3'd0;
    localparam kind_t OP_NEWLINE   = 3'd1;
    localparam kind_t OP_RETURN    = 3'd2;
    localparam kind_t OP_BACKSPACE = 3'd3;
    localparam kind_t OP_DRAW      = 3'd4;
    localparam kind_t OP_CLEAR     = 3'd5;
    localparam kind_t OP_READ      = 3'd6;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              in_range;
    } op_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

// File: hdl/tcce_stream_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcce_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [tcce_pkg::CHAR_W-1:0] char_code;
    logic [3:0]                  fg_color;
    logic [3:0]                  bg_color;
    logic [tcce_pkg::COL_W-1:0]  cell_col;
    logic [tcce_pkg::ROW_W-1:0]  cell_row;

    modport source (
        output valid, mode, char_code, fg_color, bg_color, cell_col, cell_row,
        input  ready
    );
    modport sink (
        input  valid, mode, char_code, fg_color, bg_color, cell_col, cell_row,
        output ready
    );
endinterface

interface tcce_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tcce_pkg::COL_W-1:0]  cursor_col_out;
    logic [tcce_pkg::ROW_W-1:0]  cursor_row_out;
    logic [tcce_pkg::CELL_W-1:0] cell_data;
    logic                        scrolled;

    modport source (
        output valid, cursor_col_out, cursor_row_out, cell_data, scrolled,
        input  ready
    );
    modport sink (
        input  valid, cursor_col_out, cursor_row_out, cell_data, scrolled,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/tcce_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tcce_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    tcce_cmd_if.sink        cmd,
    input  logic            init_busy,
    output logic            push_valid,
    input  logic            push_ready,
    output tcce_pkg::op_t   push_op
);

    logic col_ok;
    logic row_ok;

    assign cmd.ready  = push_ready && !init_busy;
    assign push_valid = cmd.valid && !init_busy;

    assign col_ok = {1'b0, cmd.cell_col} < (tcce_pkg::COL_W + 1)'(COLUMNS);
    assign row_ok = {1'b0, cmd.cell_row} < (tcce_pkg::ROW_W + 1)'(ROWS);

    always_comb
    begin
        push_op.ch       = cmd.char_code;
        push_op.attr     = {cmd.bg_color, cmd.fg_color};
        push_op.col      = cmd.cell_col;
        push_op.row      = cmd.cell_row;
        push_op.in_range = col_ok && row_ok;
        unique case (cmd.mode)
            tcce_pkg::MODE_PUT:
            begin
                priority if (cmd.char_code == tcce_pkg::CH_NEWLINE)
                    push_op.kind = tcce_pkg::OP_NEWLINE;
                else if (cmd.char_code == tcce_pkg::CH_RETURN)
                    push_op.kind = tcce_pkg::OP_RETURN;
                else if (cmd.char_code == tcce_pkg::CH_BACKSPACE)
                    push_op.kind = tcce_pkg::OP_BACKSPACE;
                else
                    push_op.kind = tcce_pkg::OP_PRINT;
            end
            tcce_pkg::MODE_DRAW:  push_op.kind = tcce_pkg::OP_DRAW;
            tcce_pkg::MODE_CLEAR: push_op.kind = tcce_pkg::OP_CLEAR;
            tcce_pkg::MODE_READ:  push_op.kind = tcce_pkg::OP_READ;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/tcce_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tcce_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tcce_pkg::op_t push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tcce_pkg::op_t pop_op
);

    localparam logic [tcce_pkg::Q_PTR_W-1:0] LAST_PTR =
        tcce_pkg::Q_PTR_W'(tcce_pkg::QUEUE_DEPTH - 1);
    localparam logic [tcce_pkg::Q_CNT_W-1:0] FULL_CNT =
        tcce_pkg::Q_CNT_W'(tcce_pkg::QUEUE_DEPTH);

    tcce_pkg::op_t                entry_reg [tcce_pkg::QUEUE_DEPTH];
    logic [tcce_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tcce_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tcce_pkg::Q_CNT_W-1:0] count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

// File: hdl/tcce_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tcce_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcce_pkg::ATTR_W-1:0]   attr,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  tcce_pkg::op_t                 pop_op,
    output logic                          init_busy,
    tcce_rsp_if.source                    rsp
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP      = ADDR_W'(COLUMNS);
    localparam logic [tcce_pkg::COL_W-1:0] LAST_COL = tcce_pkg::COL_W'(COLUMNS - 1);
    localparam logic [tcce_pkg::ROW_W-1:0] LAST_ROW = tcce_pkg::ROW_W'(ROWS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;

    logic [tcce_pkg::CELL_W-1:0] mem [CELLS];
    logic [tcce_pkg::CELL_W-1:0] rdata_reg;

    logic [2:0]                  state_reg, state_next;
    logic [ADDR_W-1:0]           cnt_reg, cnt_next;
    logic [tcce_pkg::CELL_W-1:0] fill_data_reg, fill_data_next;
    logic                        report_reg, report_next;
    logic                        scroll_flag_reg, scroll_flag_next;
    logic                        init_done_reg, init_done_next;
    logic [tcce_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcce_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0]           caddr_reg, caddr_next;

    logic                        out_valid_reg, out_valid_next;
    logic [tcce_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [tcce_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic [tcce_pkg::CELL_W-1:0] out_data_reg, out_data_next;
    logic                        out_scrolled_reg, out_scrolled_next;

    logic                        we;
    logic [ADDR_W-1:0]           waddr;
    logic [tcce_pkg::CELL_W-1:0] wdata;
    logic                        re;
    logic [ADDR_W-1:0]           raddr;
    logic [ADDR_W-1:0]           op_addr;
    logic                        out_free;
    logic                        do_pop;
    logic                        load_out;
    logic [tcce_pkg::CELL_W-1:0] res_data;
    logic                        res_scrolled;
    logic [tcce_pkg::CELL_W-1:0] blank_cell;

    assign op_addr    = ADDR_W'(ADDR_W'(pop_op.row) * ROW_STEP + ADDR_W'(pop_op.col));
    assign out_free   = !out_valid_reg || rsp.ready;
    assign pop_ready  = (state_reg == S_IDLE) && init_done_reg && out_free;
    assign do_pop     = pop_ready && pop_valid;
    assign init_busy  = !init_done_reg;
    assign blank_cell = {attr, tcce_pkg::CH_SPACE};

    assign rsp.valid          = out_valid_reg;
    assign rsp.cursor_col_out = out_col_reg;
    assign rsp.cursor_row_out = out_row_reg;
    assign rsp.cell_data      = out_data_reg;
    assign rsp.scrolled       = out_scrolled_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        fill_data_next   = fill_data_reg;
        report_next      = report_reg;
        scroll_flag_next = scroll_flag_reg;
        init_done_next   = init_done_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        caddr_next       = caddr_reg;
        we               = 1'b0;
        waddr            = caddr_reg;
        wdata            = blank_cell;
        re               = 1'b0;
        raddr            = op_addr;
        load_out         = 1'b0;
        res_data         = '0;
        res_scrolled     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (do_pop)
                begin
                    unique case (pop_op.kind)
                        tcce_pkg::OP_PRINT:
                        begin
                            we    = 1'b1;
                            wdata = {attr, pop_op.ch};
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    caddr_next = LAST_ROW_BASE;
                                    cnt_next   = '0;
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    row_next   = row_reg + 1'b1;
                                    caddr_next = caddr_reg + 1'b1;
                                    load_out   = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next   = col_reg + 1'b1;
                                caddr_next = caddr_reg + 1'b1;
                                load_out   = 1'b1;
                            end
                        end
                        tcce_pkg::OP_NEWLINE:
                        begin
                            col_next = '0;
                            if (row_reg == LAST_ROW)
                            begin
                                caddr_next = LAST_ROW_BASE;
                                cnt_next   = '0;
                                state_next = S_SCROLL;
                            end
                            else
                            begin
                                row_next   = row_reg + 1'b1;
                                caddr_next = caddr_reg - ADDR_W'(col_reg) + ROW_STEP;
                                load_out   = 1'b1;
                            end
                        end
                        tcce_pkg::OP_RETURN:
                        begin
                            col_next   = '0;
                            caddr_next = caddr_reg - ADDR_W'(col_reg);
                            load_out   = 1'b1;
                        end
                        tcce_pkg::OP_BACKSPACE:
                        begin
                            load_out = 1'b1;
                            if (col_reg != '0 || row_reg != '0)
                            begin
                                if (col_reg == '0)
                                begin
                                    row_next = row_reg - 1'b1;
                                    col_next = LAST_COL;
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                                caddr_next = caddr_reg - 1'b1;
                                we         = 1'b1;
                                waddr      = caddr_reg - 1'b1;
                            end
                        end
                        tcce_pkg::OP_DRAW:
                        begin
                            we       = pop_op.in_range;
                            waddr    = op_addr;
                            wdata    = {pop_op.attr, pop_op.ch};
                            load_out = 1'b1;
                        end
                        tcce_pkg::OP_CLEAR:
                        begin
                            col_next         = '0;
                            row_next         = '0;
                            caddr_next       = '0;
                            cnt_next         = '0;
                            fill_data_next   = blank_cell;
                            report_next      = 1'b1;
                            scroll_flag_next = 1'b0;
                            state_next       = S_FILL;
                        end
                        tcce_pkg::OP_READ:
                        begin
                            if (pop_op.in_range)
                            begin
                                re         = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                load_out = 1'b1;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_data   = rdata_reg;
                load_out   = 1'b1;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                // read runs one row ahead; each word read is written back through rdata_reg in the next cycle
                if (cnt_reg != LAST_ROW_BASE)
                begin
                    re    = 1'b1;
                    raddr = cnt_reg + ROW_STEP;
                end
                if (cnt_reg != '0)
                begin
                    we    = 1'b1;
                    waddr = cnt_reg - 1'b1;
                    wdata = rdata_reg;
                end
                if (cnt_reg == LAST_ROW_BASE)
                begin
                    fill_data_next   = blank_cell;
                    report_next      = 1'b1;
                    scroll_flag_next = 1'b1;
                    state_next       = S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FILL:
            begin
                we    = 1'b1;
                waddr = cnt_reg;
                wdata = fill_data_reg;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next     = S_IDLE;
                    init_done_next = 1'b1;
                    load_out       = report_reg;
                    res_scrolled   = scroll_flag_reg;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next    = out_valid_reg && !rsp.ready;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        out_data_next     = out_data_reg;
        out_scrolled_next = out_scrolled_reg;
        if (load_out)
        begin
            out_valid_next    = 1'b1;
            out_col_next      = col_next;
            out_row_next      = row_next;
            out_data_next     = res_data;
            out_scrolled_next = res_scrolled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_FILL;
            cnt_reg         <= '0;
            fill_data_reg   <= tcce_pkg::RESET_CELL;
            report_reg      <= 1'b0;
            scroll_flag_reg <= 1'b0;
            init_done_reg   <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            caddr_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            fill_data_reg   <= fill_data_next;
            report_reg      <= report_next;
            scroll_flag_reg <= scroll_flag_next;
            init_done_reg   <= init_done_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            caddr_reg       <= caddr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_col_reg      <= out_col_next;
        out_row_reg      <= out_row_next;
        out_data_reg     <= out_data_next;
        out_scrolled_reg <= out_scrolled_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    a_caddr_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |->
            caddr_reg == ADDR_W'(ADDR_W'(row_reg) * ROW_STEP + ADDR_W'(col_reg)))
        else $error("cursor address out of step with row/col");

    a_long_op_output_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_SCROLL) |-> !out_valid_reg)
        else $error("output register busy while an op is in flight");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.scrolled |->
            rsp.cursor_row_out == LAST_ROW && rsp.cursor_col_out == '0)
        else $error("scroll result with cursor off the last row start");

    a_no_beat_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        !init_done_reg |=> !rsp.valid || init_done_reg)
        else $error("result beat during power-up clearing pass");

endmodule

`default_nettype wire

// File: hdl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Text console engine: a ROWS x COLUMNS screen memory of 16-bit cells
// (attribute 15:8, character 7:0) plus a teletype-style cursor. Commands
// enter on cmd, one result beat per command leaves on rsp; the current
// attribute is the APB register at address 0. After reset the block clears
// the screen memory to 0x0720, one cell per cycle (ROWS*COLUMNS cells, 2000
// at the defaults) and holds cmd.ready low meanwhile. A two-entry command
// queue sits between the decoder and the executing back end. Print, control
// characters and draw cell sustain one command per cycle while rsp.ready
// keeps up and no scroll is needed; a read stops in S_READ for the
// registered memory read. Clear walks the memory once; a scroll copies every
// cell of the rows below the first up one row through the single-port-write
// memory and blanks the last row.
module text_console_cursor_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tcce_cmd_if.sink                       cmd,
    tcce_rsp_if.source                     rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcce_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcce_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcce_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [tcce_pkg::ATTR_W-1:0] attr_reg, attr_next;
    logic                        attr_wr;
    logic                        init_busy;
    logic                        push_valid;
    logic                        push_ready;
    tcce_pkg::op_t               push_op;
    logic                        pop_valid;
    logic                        pop_ready;
    tcce_pkg::op_t               pop_op;

    assign pready    = 1'b1;
    assign attr_wr   = psel && penable && pwrite && pready &&
                       (paddr == tcce_pkg::REG_TEXT_ATTR);
    assign attr_next = attr_wr ? pwdata[tcce_pkg::ATTR_W-1:0] : attr_reg;
    assign prdata    = (paddr == tcce_pkg::REG_TEXT_ATTR) ?
                       tcce_pkg::PDATA_W'(attr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_reg <= tcce_pkg::ATTR_RESET;
        else
            attr_reg <= attr_next;
    end

    tcce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .cmd        (cmd),
        .init_busy  (init_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    tcce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    tcce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .attr      (attr_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .init_busy (init_busy),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
